@@ rtl/imhq_pkg.sv @@
`timescale 1ns / 1ps
package imhq_pkg;

   localparam int LABEL_W = 8;
   localparam int COST_W  = 32;
   localparam int LABELS  = 1 << LABEL_W;

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_POP    = 2'd2;

   typedef struct packed {
      logic [1:0]                action;
      logic [LABEL_W-1:0]        label;
      logic signed [COST_W-1:0]  cost;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [LABEL_W-1:0]  popped_label;
      logic                now_empty;
   } rsp_type;

   typedef struct packed {
      logic signed [COST_W-1:0]  cost;
      logic [LABEL_W-1:0]        label;
   } entry_type;

endpackage

@@ rtl/imhq_slot_map.sv @@
`timescale 1ns / 1ps
module imhq_slot_map #(
   parameter int SLOT_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [imhq_pkg::LABEL_W-1:0] query_label,
   output logic                        query_present,
   input  logic [imhq_pkg::LABEL_W-1:0] rd_label,
   output logic [SLOT_W-1:0]           rd_slot,
   input  logic                        wr_en,
   input  logic [imhq_pkg::LABEL_W-1:0] wr_label,
   input  logic [SLOT_W-1:0]           wr_slot,
   input  logic                        clr_en,
   input  logic [imhq_pkg::LABEL_W-1:0] clr_label
);
   import imhq_pkg::*;

   logic [SLOT_W-1:0] slot_mem [LABELS];
   logic [LABELS-1:0] present_ff;
   logic [LABELS-1:0] present_in;
   logic [SLOT_W-1:0] rd_slot_ff;

   // A label is present exactly while its entry sits in the heap.
   always_comb begin
      present_in = present_ff;
      if (wr_en) begin
         present_in[wr_label] = 1'b1;
      end
      if (clr_en) begin
         present_in[clr_label] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_label] <= wr_slot;
      end
      rd_slot_ff <= slot_mem[rd_label];
   end

   assign rd_slot       = rd_slot_ff;
   assign query_present = present_ff[query_label];

endmodule

@@ rtl/indexed_min_heap_queue_core.sv @@
`timescale 1ns / 1ps
// Channel   | Ports                  | Direction | Handshake
// command   | start, busy, req       | in        | taken when start is high and busy is low
// result    | rsp_valid, rsp         | out       | one-cycle strobe, always taken
//
// Each transaction produces exactly one result, strobed in the same cycle that busy drops, or
// in the cycle after acceptance when it is refused. A push climbs level by level, reading each
// parent and moving it down into the hole; an update first looks up the label's slot. A pop
// reads the root and the last entry, then sinks level by level, reading left then right child.
// The single read port of the heap memory serialises these reads. Synchronous reset clears the
// entry count and the label presence bits at once. The receiver cannot stall.
module indexed_min_heap_queue_core #(
   parameter int CAPACITY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  imhq_pkg::req_type req,
   output logic              rsp_valid,
   output imhq_pkg::rsp_type rsp
);
   import imhq_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_UPD   = 4'd1;
   localparam logic [3:0] ST_POPA  = 4'd2;
   localparam logic [3:0] ST_POPB  = 4'd3;
   localparam logic [3:0] ST_UPISS = 4'd4;
   localparam logic [3:0] ST_UPCMP = 4'd5;
   localparam logic [3:0] ST_DNISS = 4'd6;
   localparam logic [3:0] ST_DNL   = 4'd7;
   localparam logic [3:0] ST_DNR   = 4'd8;

   // Heap memory: one write and one registered read per cycle.
   entry_type heap_mem [CAPACITY];
   entry_type heap_rd_ff;
   logic [IW-1:0] heap_raddr;
   logic          heap_we;
   logic [IW-1:0] heap_waddr;
   entry_type     heap_wdata;

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_waddr] <= heap_wdata;
      end
      heap_rd_ff <= heap_mem[heap_raddr];
   end

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   entry_type     cur_ff, cur_in;
   entry_type     left_ff, left_in;
   logic [LABEL_W-1:0] popped_ff, popped_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          present;
   logic [IW-1:0] slot_rd;
   logic          slot_we;
   logic [LABEL_W-1:0] slot_wlabel;
   logic [IW-1:0] slot_wslot;
   logic          slot_clr;

   imhq_slot_map #(.SLOT_W(IW)) u_slot_map (
      .clock         (clock),
      .reset         (reset),
      .query_label   (req.label),
      .query_present (present),
      .rd_label      (req.label),
      .rd_slot       (slot_rd),
      .wr_en         (slot_we),
      .wr_label      (slot_wlabel),
      .wr_slot       (slot_wslot),
      .clr_en        (slot_clr),
      .clr_label     (popped_ff)
   );

   logic          label_ok;
   logic [XW-1:0] left_x, right_x;
   logic [IW-1:0] parent;
   entry_type     best;
   logic          take_right;

   assign label_ok = ({{(32-LABEL_W){1'b0}}, req.label} < 32'(CAPACITY));
   assign left_x   = XW'({pos_ff, 1'b1});
   assign right_x  = left_x + XW'(1);
   assign parent   = IW'((pos_ff - IW'(1)) >> 1);
   assign best       = (cur_ff.cost > left_ff.cost) ? left_ff : cur_ff;
   assign take_right = (right_x < XW'(count_ff)) && (best.cost > heap_rd_ff.cost);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      popped_in    = popped_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      heap_raddr   = '0;
      heap_we      = 1'b0;
      heap_waddr   = pos_ff;
      heap_wdata   = cur_ff;
      slot_we      = 1'b0;
      slot_wlabel  = cur_ff.label;
      slot_wslot   = pos_ff;
      slot_clr     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cur_in    = '{cost: req.cost, label: req.label};
               popped_in = '0;
               rsp_in    = '{accepted: 1'b0, popped_label: '0, now_empty: (count_ff == '0)};
               case (req.action)
                  ACT_PUSH: begin
                     if ((count_ff < CW'(CAPACITY)) && label_ok && !present) begin
                        pos_in   = IW'(count_ff);
                        count_in = count_ff + CW'(1);
                        state_in = ST_UPISS;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ACT_UPDATE: begin
                     if (label_ok && present) begin
                        state_in = ST_UPD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ACT_POP: begin
                     if (count_ff != '0) begin
                        heap_raddr = '0;
                        state_in   = ST_POPA;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_UPD: begin
            pos_in   = slot_rd;
            state_in = ST_UPISS;
         end
         ST_POPA: begin
            popped_in  = heap_rd_ff.label;
            heap_raddr = IW'(count_ff - CW'(1));
            state_in   = ST_POPB;
         end
         ST_POPB: begin
            // The root's label leaves the heap; the last entry refills the root.
            slot_clr = 1'b1;
            count_in = count_ff - CW'(1);
            cur_in   = heap_rd_ff;
            pos_in   = '0;
            if (count_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{accepted: 1'b1, popped_label: popped_ff, now_empty: 1'b1};
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DNISS;
            end
         end
         ST_UPISS: begin
            if (pos_ff == '0) begin
               heap_we      = 1'b1;
               slot_we      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{accepted: 1'b1, popped_label: '0, now_empty: 1'b0};
               state_in     = ST_IDLE;
            end else begin
               heap_raddr = parent;
               state_in   = ST_UPCMP;
            end
         end
         ST_UPCMP: begin
            heap_we = 1'b1;
            slot_we = 1'b1;
            if (heap_rd_ff.cost > cur_ff.cost) begin
               // Parent moves down into the hole; the hole climbs.
               heap_wdata  = heap_rd_ff;
               slot_wlabel = heap_rd_ff.label;
               pos_in      = parent;
               state_in    = ST_UPISS;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{accepted: 1'b1, popped_label: '0, now_empty: 1'b0};
               state_in     = ST_IDLE;
            end
         end
         ST_DNISS: begin
            if (left_x >= XW'(count_ff)) begin
               heap_we      = 1'b1;
               slot_we      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{accepted: 1'b1, popped_label: popped_ff, now_empty: 1'b0};
               state_in     = ST_IDLE;
            end else begin
               heap_raddr = IW'(left_x);
               state_in   = ST_DNL;
            end
         end
         ST_DNL: begin
            left_in    = heap_rd_ff;
            heap_raddr = IW'(right_x);
            state_in   = ST_DNR;
         end
         ST_DNR: begin
            heap_we = 1'b1;
            slot_we = 1'b1;
            if (take_right) begin
               heap_wdata  = heap_rd_ff;
               slot_wlabel = heap_rd_ff.label;
               pos_in      = IW'(right_x);
               state_in    = ST_DNISS;
            end else if (cur_ff.cost > left_ff.cost) begin
               heap_wdata  = left_ff;
               slot_wlabel = left_ff.label;
               pos_in      = IW'(left_x);
               state_in    = ST_DNISS;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{accepted: 1'b1, popped_label: popped_ff, now_empty: 1'b0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      left_ff   <= left_in;
      popped_ff <= popped_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
